@@ sv/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the UTF-8 encoder for the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

  // Default counter width and queue depth
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Port widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int ERR_CHAR_W  = 7;
  localparam int LIMIT_W     = 16;
  localparam int STAT_CNT_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SUBST_CHAR = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_LIMIT  = 1'b1;

  // Register reset values
  localparam logic [ERR_CHAR_W-1:0] SUBST_CHAR_RST = 7'h3F;
  localparam logic [LIMIT_W-1:0]    OUT_LIMIT_RST  = 16'hFFFF;

  // Surrogate ranges (top six bits of a code unit)
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;  // 0xDC00..0xDFFF

  // Code point limits and UTF-8 lead and continuation markers
  localparam logic [20:0] CP_SUPP_BASE = 21'h10000;
  localparam logic [20:0] CP_1BYTE_END = 21'h00080;
  localparam logic [20:0] CP_2BYTE_END = 21'h00800;
  localparam logic [7:0]  UTF8_CONT    = 8'h80;
  localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
  localparam logic [7:0]  UTF8_LEAD4   = 8'hF0;

  // One encoded character, first byte in the low bits
  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  len;
  } enc_t;

  // Control part of one queue entry
  typedef struct packed {
    logic [31:0] bytes;    // bytes of this code unit, first byte lowest
    logic [2:0]  nbytes;   // 0 marks a status-only entry
    logic [2:0]  nfirst;   // byte count of the first character
    logic        err;      // error flag after this unit
    logic        halt;     // buffer error flag after this unit
    logic        last;     // unit ends the message
  } hdr_t;

  // Encode one code point as UTF-8
  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp < CP_1BYTE_END) begin
      e.len        = 3'd1;
      e.bytes[7:0] = {1'b0, cp[6:0]};
    end else if (cp < CP_2BYTE_END) begin
      e.len         = 3'd2;
      e.bytes[7:0]  = UTF8_LEAD2 | {3'b000, cp[10:6]};
      e.bytes[15:8] = UTF8_CONT | {2'b00, cp[5:0]};
    end else if (cp < CP_SUPP_BASE) begin
      e.len          = 3'd3;
      e.bytes[7:0]   = UTF8_LEAD3 | {4'b0000, cp[15:12]};
      e.bytes[15:8]  = UTF8_CONT | {2'b00, cp[11:6]};
      e.bytes[23:16] = UTF8_CONT | {2'b00, cp[5:0]};
    end else begin
      e.len          = 3'd4;
      e.bytes[7:0]   = UTF8_LEAD4 | {5'b00000, cp[20:18]};
      e.bytes[15:8]  = UTF8_CONT | {2'b00, cp[17:12]};
      e.bytes[23:16] = UTF8_CONT | {2'b00, cp[11:6]};
      e.bytes[31:24] = UTF8_CONT | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

@@ sv/u16u8_front.sv @@
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates, checks the byte limit and keeps the
// message state; writes one entry per unit that has results.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_front import u16u8_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input stream
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [IN_TDATA_W-1:0]      code_unit,
  input  wire logic                       last_unit,
  // configuration
  input  wire logic [ERR_CHAR_W-1:0]      subst_char,
  input  wire logic [LIMIT_W-1:0]         out_limit,
  // queue write side
  input  wire logic                       q_full,
  output      logic                       q_push,
  output      hdr_t                       ent_hdr,
  output      logic [4*COUNT_WIDTH-1:0]   ent_cnt
);

  localparam int CW    = COUNT_WIDTH;
  localparam int CMP_W = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

  // Message state
  logic          pend_r, pend_nxt;
  logic [9:0]    phigh_r, phigh_nxt;
  logic          err_r, err_nxt;
  logic          halt_r, halt_nxt;
  logic [CW-1:0] ucnt_r, ucnt_nxt;
  logic [CW-1:0] bcnt_r, bcnt_nxt;

  logic          accept;
  logic          is_low, is_high;
  logic [20:0]   pair_cp, err_cp, a_cp, b_cp;
  enc_t          enc_a, enc_b;
  logic          s1, a_fit, a_emit, halt1, handled, s2;
  logic          b_try, b_fit, b_emit, halt2;
  logic          err2, pend2;
  logic [CW-1:0] bcnt1, ucnt1, bcnt2, ucnt2;
  logic [2:0]    len_a, len_b;
  logic          has_res;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the unit and build both candidate characters
  always_comb begin
    is_low  = (code_unit[15:10] == LOW_SURR_TAG);
    is_high = (code_unit[15:10] == HIGH_SURR_TAG);
    pair_cp = CP_SUPP_BASE + {1'b0, phigh_r, code_unit[9:0]};
    err_cp  = 21'(subst_char);
    a_cp    = is_low ? pair_cp : err_cp;
    b_cp    = is_high ? err_cp : 21'(code_unit);
    enc_a   = utf8_encode(a_cp);
    enc_b   = utf8_encode(b_cp);
  end

  // Resolve the held high surrogate first, then the unit itself
  always_comb begin
    s1      = !halt_r && pend_r;
    a_fit   = (CMP_W'(bcnt_r) + CMP_W'(enc_a.len)) <= CMP_W'(out_limit);
    a_emit  = s1 && a_fit;
    halt1   = halt_r || (s1 && !a_fit);
    handled = s1 && (is_low || !a_fit);
    s2      = !handled && !halt1;
    // a high surrogate that ends the message turns into the error character
    b_try   = s2 && (!is_high || last_unit);
    bcnt1   = a_emit ? bcnt_r + CW'(enc_a.len) : bcnt_r;
    ucnt1   = a_emit ? ucnt_r + (is_low ? CW'(2) : CW'(1)) : ucnt_r;
    b_fit   = (CMP_W'(bcnt1) + CMP_W'(enc_b.len)) <= CMP_W'(out_limit);
    b_emit  = b_try && b_fit;
    halt2   = halt1 || (b_try && !b_fit);
    bcnt2   = b_emit ? bcnt1 + CW'(enc_b.len) : bcnt1;
    ucnt2   = b_emit ? ucnt1 + CW'(1) : ucnt1;
    err2    = err_r || (s1 && !is_low) || (s2 && is_high && last_unit);
    pend2   = s2 && is_high && !last_unit;
    len_a   = a_emit ? enc_a.len : 3'd0;
    len_b   = b_emit ? enc_b.len : 3'd0;
  end

  // Build the entry; two characters only occur as error char then unit
  always_comb begin
    ent_hdr.nbytes = len_a + len_b;
    ent_hdr.nfirst = a_emit ? len_a : len_b;
    if (a_emit) begin
      ent_hdr.bytes = enc_a.bytes | (b_emit ? {enc_b.bytes[23:0], 8'h00} : 32'h0);
    end else begin
      ent_hdr.bytes = b_emit ? enc_b.bytes : 32'h0;
    end
    ent_hdr.err  = err2;
    ent_hdr.halt = halt2;
    ent_hdr.last = last_unit;
    ent_cnt      = {bcnt_r, ucnt2, ucnt1, ucnt_r};
    has_res      = (ent_hdr.nbytes != 3'd0) || last_unit || (halt2 && !halt_r);
    q_push       = accept && has_res;
  end

  // Advance message state; clear it at the end of a message
  always_comb begin
    pend_nxt  = pend_r;
    phigh_nxt = phigh_r;
    err_nxt   = err_r;
    halt_nxt  = halt_r;
    ucnt_nxt  = ucnt_r;
    bcnt_nxt  = bcnt_r;
    if (accept) begin
      if (last_unit) begin
        pend_nxt = 1'b0;
        err_nxt  = 1'b0;
        halt_nxt = 1'b0;
        ucnt_nxt = '0;
        bcnt_nxt = '0;
      end else begin
        pend_nxt = pend2;
        err_nxt  = err2;
        halt_nxt = halt2;
        ucnt_nxt = ucnt2;
        bcnt_nxt = bcnt2;
      end
      if (pend2) begin
        phigh_nxt = code_unit[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      err_r  <= 1'b0;
      halt_r <= 1'b0;
      ucnt_r <= '0;
      bcnt_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      err_r  <= err_nxt;
      halt_r <= halt_nxt;
      ucnt_r <= ucnt_nxt;
      bcnt_r <= bcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phigh_r <= phigh_nxt;
  end

endmodule

`default_nettype wire

@@ sv/u16u8_queue.sv @@
// ----------------------------------------------------------------------------
// u16u8_queue
// Short first-in first-out queue of unit entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_queue import u16u8_pkg::*; #(
  parameter int DEPTH  = QUEUE_DEPTH_DEF,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] din,
  output      logic              full,
  input  wire logic              pop,
  output      logic              not_empty,
  output      logic [DATA_W-1:0] dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign dout      = mem[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

@@ sv/u16u8_back.sv @@
// ----------------------------------------------------------------------------
// u16u8_back
// Walks the head entry one result per cycle while the sink keeps up and
// drives the registered output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_back import u16u8_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // queue read side
  input  wire logic                       q_valid,
  input  wire hdr_t                       ent_hdr,
  input  wire logic [4*COUNT_WIDTH-1:0]   ent_cnt,
  output      logic                       q_pop,
  // output stream
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [OUT_TDATA_W-1:0]     out_data,
  output      logic                       out_user,
  output      logic                       out_last
);

  localparam int CW = COUNT_WIDTH;

  logic                   valid_r, valid_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic [OUT_TDATA_W-1:0] data_r;
  logic                   user_r, last_r;

  logic                   load, is_status, end_ent;
  logic [2:0]             i1;
  logic [CW-1:0]          u0, ua, uf, b0, units, bw;
  logic [7:0]             cur_byte;
  logic                   run_last, done, buf_err;
  logic [OUT_TDATA_W-1:0] data_nxt;

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_user  = user_r;
  assign out_last  = last_r;

  // Pick the result at the current byte index
  always_comb begin
    {b0, uf, ua, u0} = ent_cnt;
    load      = q_valid && (!valid_r || out_ready);
    is_status = (ent_hdr.nbytes == 3'd0);
    i1        = {1'b0, idx_r} + 3'd1;
    end_ent   = is_status || (i1 == ent_hdr.nbytes);
    q_pop     = load && end_ent;
    cur_byte  = is_status ? 8'h00 : ent_hdr.bytes[{idx_r, 3'b000} +: 8];
    run_last  = end_ent;
    done      = end_ent && ent_hdr.last;
    buf_err   = is_status && ent_hdr.halt;
    if (is_status) begin
      units = uf;
      bw    = b0;
    end else begin
      // the unit count steps on the last byte of each character
      units = (i1 < ent_hdr.nfirst) ? u0 : ((i1 < ent_hdr.nbytes) ? ua : uf);
      bw    = b0 + CW'(i1);
    end
    data_nxt = {5'b00000, STAT_CNT_W'(bw), STAT_CNT_W'(units),
                buf_err, ent_hdr.err, run_last, cur_byte};
    idx_nxt  = load ? (end_ent ? 2'd0 : idx_r + 2'd1) : idx_r;
    valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Hold the payload until the sink takes it
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      user_r <= !is_status;
      last_r <= done;
    end
  end

endmodule

`default_nettype wire

@@ sv/utf16_to_utf8_transcoder_core.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// UTF-16 code units in, UTF-8 bytes with message status out.
// ----------------------------------------------------------------------------
// The block takes one code unit per cycle while its two-entry unit queue has
// room and sends one result per cycle on the output stream while out_tready
// allows it: one per UTF-8 byte a unit produces (or one for a status-only
// result), as the output register carries one byte. The first result of a
// unit passes through the unit queue and then the output register. A high
// surrogate produces nothing until the next unit; an unpaired one becomes
// the error character. Once a character would pass out_limit, the rest of
// the message is dropped and a status-only result carries buffer_error.
// Counters restart with each message. Write configuration only while no
// transaction is in flight.
`default_nettype none

module utf16_to_utf8_transcoder_core import u16u8_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  // code unit stream
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] code_unit
  input  wire logic                   in_tlast,   // last_unit
  // UTF-8 result stream
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  // [7:0] out_byte, [8] run_last, [9] had_errors, [10] buffer_error,
  // [26:11] units_consumed, [42:27] bytes_written, [47:43] zero
  output      logic [OUT_TDATA_W-1:0] out_tdata,
  output      logic                   out_tuser,  // [0] byte_valid
  output      logic                   out_tlast   // message_done
);

  localparam int CNT_VEC_W = 4 * COUNT_WIDTH;
  localparam int ENT_W     = $bits(hdr_t) + CNT_VEC_W;

  logic [ERR_CHAR_W-1:0] subst_char_r;
  logic [LIMIT_W-1:0]    out_limit_r;

  logic                  q_full, q_push, q_pop, q_valid;
  hdr_t                  f_hdr, b_hdr;
  logic [CNT_VEC_W-1:0]  f_cnt, b_cnt;
  logic [ENT_W-1:0]      q_dout;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subst_char_r <= SUBST_CHAR_RST;
      out_limit_r  <= OUT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SUBST_CHAR: subst_char_r <= cfg_wdata[ERR_CHAR_W-1:0];
        REG_OUT_LIMIT:  out_limit_r  <= cfg_wdata[LIMIT_W-1:0];
        default:        ;
      endcase
    end
  end

  u16u8_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .code_unit  (in_tdata),
    .last_unit  (in_tlast),
    .subst_char (subst_char_r),
    .out_limit  (out_limit_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .ent_hdr    (f_hdr),
    .ent_cnt    (f_cnt)
  );

  u16u8_queue #(
    .DEPTH  (QUEUE_DEPTH_DEF),
    .DATA_W (ENT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       ({f_hdr, f_cnt}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .dout      (q_dout)
  );

  assign {b_hdr, b_cnt} = q_dout;

  u16u8_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .ent_hdr   (b_hdr),
    .ent_cnt   (b_cnt),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_user  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

@@ sv/u16u8_checker.sv @@
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks on the transcoder result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_checker import u16u8_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser,
  input wire logic                   out_tlast
);

  // A stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Status-only results carry a zero byte and mark the end of a run
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'h00 && out_tdata[8])
    else $error("status result with byte or without run end");

  // End of message is always the end of a unit's run
  a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[8])
    else $error("message end inside a run");

  // A delivered byte never carries the buffer error
  a_byte_no_buf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[10])
    else $error("byte sent after buffer error");

endmodule

bind utf16_to_utf8_transcoder_core u16u8_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-16 to UTF-8 transcoder core.
// A directed table covers the encoding range edges, surrogate pairs, unpaired
// and lone surrogates and output limit overflow. Random messages then follow
// under several register settings. Every output transaction is compared field
// by field against a behavioral transcoder kept in step with the input stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import u16u8_pkg::*; ();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  // One output transaction as seen on the result stream
  typedef struct packed {
    logic [7:0]  octet;
    logic        octet_vld;
    logic        run_end;
    logic        msg_end;
    logic        err_sticky;
    logic        full_sticky;
    logic [15:0] units_done;
    logic [15:0] octets_done;
  } utf8_result_t;

  typedef enum logic {ROW_UNIT, ROW_CFG} row_kind_t;

  // Directed row: a code unit or a register write, with an optional first octet
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_ADDR_W-1:0]  reg_idx;
    logic [15:0]            val;
    logic                   last;
    logic                   typed;
    logic [7:0]             first_octet;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [15:0] code_unit
  logic                   in_tlast;   // last_unit
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  // [7:0] out_byte, [8] run_last, [9] had_errors, [10] buffer_error,
  // [26:11] units_consumed, [42:27] bytes_written, [47:43] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;  // [0] byte_valid
  logic                   out_tlast;  // message_done

  // Transcoder state mirrored by the bench
  logic [ERR_CHAR_W-1:0]  err_char;
  logic [LIMIT_W-1:0]     byte_limit;
  logic [9:0]             pend_high;
  logic                   pend_vld;
  logic                   err_seen;
  logic                   halted;
  logic [15:0]            unit_cnt;
  logic [15:0]            octet_cnt;

  utf8_result_t step_q[$];      // results of the unit being transcoded
  utf8_result_t utf8_due_q[$];  // results still owed by the core
  int unsigned  fail_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  stall_left = 0;
  bit           calm;

  stim_row_t dir_tab [29] = '{
    '{ROW_UNIT, REG_SUBST_CHAR, 16'h0000, 1'b0, 1'b1, 8'h00},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'h007F, 1'b0, 1'b1, 8'h7F},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'h0080, 1'b0, 1'b1, 8'hC2},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'h07FF, 1'b0, 1'b1, 8'hDF},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'h0800, 1'b0, 1'b1, 8'hE0},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hFFFF, 1'b0, 1'b1, 8'hEF},
    // lowest and highest surrogate pair
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hD800, 1'b0, 1'b0, 8'h00},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hDC00, 1'b0, 1'b1, 8'hF0},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hDBFF, 1'b0, 1'b0, 8'h00},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hDFFF, 1'b0, 1'b1, 8'hF4},
    // lone low surrogate encodes as a plain three-byte character
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hDC00, 1'b0, 1'b1, 8'hED},
    // unpaired high followed by ASCII, then by another high
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hD801, 1'b0, 1'b0, 8'h00},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'h0041, 1'b0, 1'b1, 8'h3F},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hD802, 1'b0, 1'b0, 8'h00},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hD803, 1'b0, 1'b1, 8'h3F},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'h0042, 1'b1, 1'b1, 8'h3F},
    // high surrogate still held at the end of a message
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hD834, 1'b1, 1'b1, 8'h3F},
    // error character that no longer fits trips the buffer error
    '{ROW_CFG,  REG_SUBST_CHAR, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  REG_OUT_LIMIT,  16'h0001, 1'b0, 1'b0, 8'h00},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'h0041, 1'b0, 1'b1, 8'h41},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hD800, 1'b0, 1'b0, 8'h00},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'h0042, 1'b0, 1'b1, 8'h00},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'h0043, 1'b1, 1'b1, 8'h00},
    // zero limit: first unit trips the buffer error and ends the message
    '{ROW_CFG,  REG_SUBST_CHAR, 16'h007F, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  REG_OUT_LIMIT,  16'h0000, 1'b0, 1'b0, 8'h00},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hFFFF, 1'b1, 1'b1, 8'h00},
    '{ROW_CFG,  REG_OUT_LIMIT,  16'hFFFF, 1'b0, 1'b0, 8'h00},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'hD9AB, 1'b0, 1'b0, 8'h00},
    '{ROW_UNIT, REG_SUBST_CHAR, 16'h5555, 1'b1, 1'b1, 8'h7F}
  };

  utf16_to_utf8_transcoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic utf8_result_t make_result(input logic [7:0] o, input logic vld);
    utf8_result_t r;
    r.octet       = o;
    r.octet_vld   = vld;
    r.run_end     = 1'b0;
    r.msg_end     = 1'b0;
    r.err_sticky  = err_seen;
    r.full_sticky = halted;
    r.units_done  = unit_cnt;
    r.octets_done = octet_cnt;
    return r;
  endfunction

  function automatic string show_result(input utf8_result_t r);
    return $sformatf("{byte %h vld %b run_last %b done %b err %b full %b units %0d bytes %0d}",
                     r.octet, r.octet_vld, r.run_end, r.msg_end, r.err_sticky,
                     r.full_sticky, r.units_done, r.octets_done);
  endfunction

  // Encode one code point; mark the message full if it does not fit
  task automatic emit_char(input logic [20:0] cp, input int unsigned units, output bit fits);
    logic [7:0]  b [4];
    int unsigned n;
    fits = 1'b0;
    if (halted) return;
    if (cp < CP_1BYTE_END) begin
      n = 1; b[0] = cp[7:0];
    end else if (cp < CP_2BYTE_END) begin
      n = 2; b[0] = UTF8_LEAD2 | {3'b000, cp[10:6]}; b[1] = UTF8_CONT | {2'b00, cp[5:0]};
    end else if (cp < CP_SUPP_BASE) begin
      n = 3; b[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]}; b[1] = UTF8_CONT | {2'b00, cp[11:6]};
      b[2] = UTF8_CONT | {2'b00, cp[5:0]};
    end else begin
      n = 4; b[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
      b[1] = UTF8_CONT | {2'b00, cp[17:12]};
      b[2] = UTF8_CONT | {2'b00, cp[11:6]}; b[3] = UTF8_CONT | {2'b00, cp[5:0]};
    end
    if (32'(octet_cnt) + n > 32'(byte_limit)) begin
      halted   = 1'b1;
      pend_vld = 1'b0;
      return;
    end
    for (int unsigned i = 0; i < n; i++) begin
      octet_cnt = octet_cnt + 16'd1;
      if (i + 1 == n) unit_cnt = unit_cnt + 16'(units);
      step_q.push_back(make_result(b[i], 1'b1));
    end
    fits = 1'b1;
  endtask

  // Transcode one accepted code unit into step_q
  task automatic transcode_unit(input logic [15:0] code, input logic last);
    bit          was_halted;
    bit          handled;
    bit          fits;
    logic [20:0] cp;
    step_q.delete();
    was_halted = halted;
    handled    = 1'b0;
    // resolve a held high surrogate first
    if (!halted && pend_vld) begin
      pend_vld = 1'b0;
      if (code >= 16'hDC00 && code < 16'hE000) begin
        cp = CP_SUPP_BASE + 21'({pend_high, code[9:0]});
        emit_char(cp, 2, fits);
        handled = 1'b1;
      end else begin
        err_seen = 1'b1;
        emit_char(21'(err_char), 1, fits);
        if (!fits) handled = 1'b1;
      end
    end
    if (!handled && !halted) begin
      if (code >= 16'hD800 && code < 16'hDC00) begin
        pend_high = code[9:0];
        pend_vld  = 1'b1;
      end else begin
        emit_char(21'(code), 1, fits);
      end
    end
    // high surrogate left over at the end of the message
    if (last && pend_vld && !halted) begin
      pend_vld = 1'b0;
      err_seen = 1'b1;
      emit_char(21'(err_char), 1, fits);
    end
    if (step_q.size() == 0 && (last || (halted && !was_halted)))
      step_q.push_back(make_result(8'h00, 1'b0));
    if (step_q.size() != 0) begin
      step_q[$].run_end = 1'b1;
      step_q[$].msg_end = last;
    end
    if (last) begin
      pend_high = '0;
      pend_vld  = 1'b0;
      err_seen  = 1'b0;
      halted    = 1'b0;
      unit_cnt  = '0;
      octet_cnt = '0;
    end
  endtask

  // Drive one code unit; called and returns at a falling edge
  task automatic send_unit(input logic [15:0] code, input logic last,
                           input logic typed, input logic [7:0] first_octet);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = code;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    transcode_unit(code, last);
    if (typed) step_q[0].octet = first_octet;
    foreach (step_q[i]) utf8_due_q.push_back(step_q[i]);
    @(negedge clk);
  endtask

  // Write a register once the core has drained
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_tvalid = 1'b0;
    while (utf8_due_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_SUBST_CHAR) err_char = val[ERR_CHAR_W-1:0];
    else byte_limit = val[LIMIT_W-1:0];
  endtask

  // Random messages under one register setting
  task automatic run_phase(input logic [6:0] ec, input logic [15:0] lim, input int unsigned n_units);
    logic [15:0] msg[$];
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    write_reg(REG_SUBST_CHAR, 16'(ec));
    write_reg(REG_OUT_LIMIT, lim);
    sent = 0;
    while (sent < n_units) begin
      msg.delete();
      len = $urandom_range(1, 8);
      // mostly well-formed text, some broken surrogates and raw noise
      while (msg.size() < len) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) msg.push_back(16'($urandom_range(0, 16'h7F)));
        else if (pick < 35) msg.push_back(16'($urandom_range(16'h80, 16'h7FF)));
        else if (pick < 43) msg.push_back(16'($urandom_range(16'h800, 16'hD7FF)));
        else if (pick < 50) msg.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
        else if (pick < 75) begin
          msg.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
          msg.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end else if (pick < 83) msg.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
        else if (pick < 90) msg.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
        else msg.push_back(16'($urandom_range(0, 16'hFFFF)));
      end
      foreach (msg[i]) send_unit(msg[i], i == msg.size() - 1, 1'b0, 8'h00);
      sent += msg.size();
    end
    in_tvalid = 1'b0;
  endtask

  // Result-side backpressure in short bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_tready = 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_tready = 1'b1;
    end
  end

  // Compare each output transaction with the oldest owed result
  always @(posedge clk) begin : chk
    utf8_result_t got;
    utf8_result_t want;
    cycle_cnt++;
    if (rst_n && out_tvalid && out_tready) begin
      got.octet       = out_tdata[7:0];
      got.octet_vld   = out_tuser;
      got.run_end     = out_tdata[8];
      got.msg_end     = out_tlast;
      got.err_sticky  = out_tdata[9];
      got.full_sticky = out_tdata[10];
      got.units_done  = out_tdata[26:11];
      got.octets_done = out_tdata[42:27];
      if (utf8_due_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected result, expected none, actual %s", $time, show_result(got));
      end else begin
        want = utf8_due_q.pop_front();
        if (got !== want) begin
          fail_cnt++;
          $display("%0t: result mismatch, expected %s, actual %s", $time,
                   show_result(want), show_result(got));
        end
      end
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Main sequence
  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    calm       = 1'b0;
    err_char   = SUBST_CHAR_RST;
    byte_limit = OUT_LIMIT_RST;
    pend_high  = '0;
    pend_vld   = 1'b0;
    err_seen   = 1'b0;
    halted     = 1'b0;
    unit_cnt   = '0;
    octet_cnt  = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_reg(dir_tab[i].reg_idx, dir_tab[i].val);
      else send_unit(dir_tab[i].val, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].first_octet);
    end
    in_tvalid = 1'b0;

    // random messages across several settings
    run_phase(7'($urandom_range(0, 127)), 16'hFFFF, 25);
    run_phase(7'h00, 16'($urandom_range(6, 40)), 25);
    run_phase(7'h7F, 16'($urandom_range(0, 16'hFFFF)), 24);
    calm = 1'b1;
    run_phase(7'($urandom_range(0, 127)), 16'hFFFF, 24);

    // drain and finish
    while (utf8_due_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
